>>> hdl/mbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbl_pkg
// Shared types and constants of the mailbox byte link: operation and status
// codes, mailbox word layout, and the control structs between the units.
// ----------------------------------------------------------------------------
package mbl_pkg;

   typedef enum logic [1:0] {
      OP_SEND_BYTE = 2'd0,
      OP_SEND_CTL  = 2'd1,
      OP_RECV_WORD = 2'd2,
      OP_POP_BYTE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_WOULD_BLOCK = 2'd1,
      STATUS_FIFO_EMPTY  = 2'd2,
      STATUS_NO_DATA     = 2'd3
   } status_type;

   // Mailbox word layout: ctl[31:26] | len[25:24] | data[23:0]
   localparam int NOTIFY_BIT   = 26;
   localparam int LEN_LSB      = 24;
   localparam int DATA_BITS    = 24;
   localparam logic [1:0] TX_FULL_COUNT = 2'd3;

   typedef struct packed {
      logic        byte_en;
      logic        flush_en;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [5:0]  ctl_bits;
   } tx_cmd_type;

   typedef struct packed {
      logic        word_valid;
      logic [31:0] word;
   } tx_rsp_type;

   typedef struct packed {
      logic                 push;
      logic                 pop;
      logic [DATA_BITS-1:0] data;
      logic [1:0]           len;
   } rx_cmd_type;

   typedef struct packed {
      logic [1:0] taken;
      logic [7:0] pop_byte;
      logic       empty;
   } rx_rsp_type;

endpackage

>>> hdl/mbl_tx_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbl_tx_pack
// Transmit packer: collects bytes low byte first into a 24-bit holding
// register and builds the outgoing mailbox word on a full, last or flush.
// ----------------------------------------------------------------------------
module mbl_tx_pack (
   input  logic                clock,
   input  logic                reset,
   input  mbl_pkg::tx_cmd_type cmd,
   output mbl_pkg::tx_rsp_type rsp
);
   import mbl_pkg::*;

   logic [DATA_BITS-1:0] pack_bytes_ff, pack_bytes_in;
   logic [1:0]           pack_count_ff, pack_count_in;
   logic [DATA_BITS-1:0] merged;
   logic [1:0]           count_inc;

   always_comb begin
      case (pack_count_ff)
         2'd0:    merged = pack_bytes_ff | {16'b0, cmd.data_byte};
         2'd1:    merged = pack_bytes_ff | {8'b0, cmd.data_byte, 8'b0};
         default: merged = pack_bytes_ff | {cmd.data_byte, 16'b0};
      endcase
   end

   assign count_inc = pack_count_ff + 2'd1;

   always_comb begin
      pack_bytes_in = pack_bytes_ff;
      pack_count_in = pack_count_ff;
      rsp           = '0;
      if (cmd.byte_en) begin
         if (count_inc == TX_FULL_COUNT || cmd.last_byte) begin
            rsp.word_valid = 1'b1;
            rsp.word       = {cmd.ctl_bits, count_inc, merged};
            pack_bytes_in  = '0;
            pack_count_in  = '0;
         end else begin
            pack_bytes_in = merged;
            pack_count_in = count_inc;
         end
      end else if (cmd.flush_en) begin
         // empty flush with no control bits sends nothing
         if (cmd.ctl_bits != 6'd0 || pack_count_ff != 2'd0) begin
            rsp.word_valid = 1'b1;
            rsp.word       = {cmd.ctl_bits, pack_count_ff, pack_bytes_ff};
            pack_bytes_in  = '0;
            pack_count_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pack_bytes_ff <= '0;
         pack_count_ff <= '0;
      end else begin
         pack_bytes_ff <= pack_bytes_in;
         pack_count_ff <= pack_count_in;
      end
   end

endmodule

>>> hdl/mbl_rx_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbl_rx_fifo
// Receive byte FIFO. Each accepted mailbox word is stored as one row of up
// to three bytes; the byte count bounds the capacity. The head row is kept
// in a registered read with write bypass, and pops step through its bytes.
// ----------------------------------------------------------------------------
module mbl_rx_fifo #(
   parameter int RX_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mbl_pkg::rx_cmd_type                 cmd,
   output mbl_pkg::rx_rsp_type                 rsp,
   output logic [$clog2(RX_DEPTH + 1) - 1:0]   level_next
);
   import mbl_pkg::*;

   localparam int AW = $clog2(RX_DEPTH);
   localparam int CW = $clog2(RX_DEPTH + 1);
   localparam int RW = DATA_BITS + 2;
   localparam logic [AW-1:0] LAST_ROW = AW'(RX_DEPTH - 1);

   logic [RW-1:0] row_mem [RX_DEPTH];
   logic [RW-1:0] row_rd_ff;
   logic [AW-1:0] rd_row_ff, rd_row_in;
   logic [AW-1:0] wr_row_ff, wr_row_in;
   logic [1:0]    head_off_ff, head_off_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] free_space;
   logic [1:0]    take;
   logic          row_write;
   logic [RW-1:0] row_wdata;
   logic [1:0]    head_len;
   logic [1:0]    off_inc;

   assign free_space = CW'(RX_DEPTH) - count_ff;
   assign take = (free_space < {{(CW - 2){1'b0}}, cmd.len}) ? free_space[1:0] : cmd.len;
   assign row_write = cmd.push && (take != 2'd0);
   assign row_wdata = {take, cmd.data};
   assign head_len  = row_rd_ff[RW-1 -: 2];
   assign off_inc   = head_off_ff + 2'd1;

   always_comb begin
      rsp          = '0;
      rsp.empty    = (count_ff == '0);
      rsp.taken    = cmd.push ? take : 2'd0;
      case (head_off_ff)
         2'd0:    rsp.pop_byte = row_rd_ff[7:0];
         2'd1:    rsp.pop_byte = row_rd_ff[15:8];
         default: rsp.pop_byte = row_rd_ff[23:16];
      endcase
      if (!cmd.pop || rsp.empty) begin
         rsp.pop_byte = 8'd0;
      end
   end

   always_comb begin
      rd_row_in   = rd_row_ff;
      wr_row_in   = wr_row_ff;
      head_off_in = head_off_ff;
      count_in    = count_ff;
      if (row_write) begin
         wr_row_in = (wr_row_ff == LAST_ROW) ? '0 : wr_row_ff + AW'(1);
         count_in  = count_ff + CW'(take);
      end else if (cmd.pop && count_ff != '0) begin
         count_in = count_ff - CW'(1);
         // advance to the next row once the head row is drained
         if (off_inc == head_len) begin
            head_off_in = 2'd0;
            rd_row_in   = (rd_row_ff == LAST_ROW) ? '0 : rd_row_ff + AW'(1);
         end else begin
            head_off_in = off_inc;
         end
      end
   end

   assign level_next = count_in;

   always_ff @(posedge clock) begin
      if (row_write) begin
         row_mem[wr_row_ff] <= row_wdata;
      end
   end

   // head row read; bypass a row written into an empty FIFO
   always_ff @(posedge clock) begin
      if (row_write && wr_row_ff == rd_row_in) begin
         row_rd_ff <= row_wdata;
      end else begin
         row_rd_ff <= row_mem[rd_row_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_row_ff   <= '0;
         wr_row_ff   <= '0;
         head_off_ff <= '0;
         count_ff    <= '0;
      end else begin
         rd_row_ff   <= rd_row_in;
         wr_row_ff   <= wr_row_in;
         head_off_ff <= head_off_in;
         count_ff    <= count_in;
      end
   end

endmodule

>>> hdl/mailbox_byte_link.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mailbox_byte_link
// Byte link between two cores over a shared mailbox: packs outgoing bytes
// into mailbox words and unpacks received words into a byte FIFO.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// req_*     in         request: op, byte, last, control bits, busy, word
// rsp_*     out        result: status, tx word, popped byte, taken, notify, level
//
// Each request passes through the input register and then the result
// register; a new request is accepted every cycle while results are taken.
// Reset clears the packer, the FIFO pointers and the byte count at once.
// A stalled result holds the result register; the input register then fills
// and req_tready drops until rsp_tready returns.
// ----------------------------------------------------------------------------
module mailbox_byte_link #(
   parameter int RX_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] data_byte, [13:8] ctl_bits, [14] remote_busy, [46:15] incoming_word
   input  logic [47:0] req_tdata,
   // [1:0] op
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] tx_word_valid, [32:1] tx_word, [40:33] rx_byte, [42:41] bytes_taken,
   // [43] notify, [50:44] fifo_level
   output logic [55:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]  rsp_tuser
);
   import mbl_pkg::*;

   localparam int CW = $clog2(RX_DEPTH + 1);

   logic        in_valid_ff;
   op_type      op_ff;
   logic [7:0]  data_byte_ff;
   logic        last_byte_ff;
   logic [5:0]  ctl_bits_ff;
   logic        remote_busy_ff;
   logic [31:0] incoming_word_ff;

   logic        out_valid_ff;
   logic [55:0] rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]  rsp_tuser_ff;
   status_type  status_in;

   logic        fire;
   logic        accept;
   tx_cmd_type  tx_cmd;
   tx_rsp_type  tx_rsp;
   rx_cmd_type  rx_cmd;
   rx_rsp_type  rx_rsp;
   logic [CW-1:0] level_next;
   logic [CW+6:0] level_ext;
   logic          is_notify;
   logic          is_zero;
   logic          notify;

   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign accept     = req_tvalid && req_tready;

   assign is_zero   = (incoming_word_ff == 32'd0);
   assign is_notify = incoming_word_ff[NOTIFY_BIT];

   always_comb begin
      tx_cmd           = '0;
      tx_cmd.data_byte = data_byte_ff;
      tx_cmd.last_byte = last_byte_ff;
      tx_cmd.ctl_bits  = ctl_bits_ff;
      tx_cmd.byte_en   = fire && !remote_busy_ff && (op_ff == OP_SEND_BYTE);
      tx_cmd.flush_en  = fire && !remote_busy_ff && (op_ff == OP_SEND_CTL);
      rx_cmd      = '0;
      rx_cmd.data = incoming_word_ff[DATA_BITS-1:0];
      rx_cmd.len  = incoming_word_ff[LEN_LSB +: 2];
      rx_cmd.push = fire && (op_ff == OP_RECV_WORD) && !is_zero && !is_notify;
      rx_cmd.pop  = fire && (op_ff == OP_POP_BYTE);
   end

   mbl_tx_pack u_tx_pack (
      .clock (clock),
      .reset (reset),
      .cmd   (tx_cmd),
      .rsp   (tx_rsp)
   );

   mbl_rx_fifo #(
      .RX_DEPTH (RX_DEPTH)
   ) u_rx_fifo (
      .clock      (clock),
      .reset      (reset),
      .cmd        (rx_cmd),
      .rsp        (rx_rsp),
      .level_next (level_next)
   );

   assign level_ext = {7'b0, level_next};

   always_comb begin
      status_in = STATUS_OK;
      notify    = 1'b0;
      case (op_ff)
         OP_SEND_BYTE, OP_SEND_CTL: begin
            if (remote_busy_ff) begin
               status_in = STATUS_WOULD_BLOCK;
            end
         end
         OP_RECV_WORD: begin
            if (is_zero) begin
               status_in = STATUS_NO_DATA;
            end else if (is_notify) begin
               notify = 1'b1;
            end else if (rx_rsp.taken == 2'd0) begin
               status_in = STATUS_NO_DATA;
            end
         end
         OP_POP_BYTE: begin
            if (rx_rsp.empty) begin
               status_in = STATUS_FIFO_EMPTY;
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
      rsp_tdata_in = {5'b0, level_ext[6:0], notify, rx_rsp.taken, rx_rsp.pop_byte,
                      tx_rsp.word, tx_rsp.word_valid};
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff            <= op_type'(req_tuser);
         data_byte_ff     <= req_tdata[7:0];
         ctl_bits_ff      <= req_tdata[13:8];
         remote_busy_ff   <= req_tdata[14];
         incoming_word_ff <= req_tdata[46:15];
         last_byte_ff     <= req_tlast;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= status_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
